FILE: rtl/lkv_pkg.sv
// Package: shared constants, request/response payload types and controller commands.
`default_nettype none
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] key;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic search;
        logic commit;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/lkv_ctrl.sv
// Controller: sequences capture, search and commit of one transaction at a time.
`default_nettype none
module lkv_ctrl
    import lkv_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  in_valid,
    output logic in_stall,
    output logic out_valid,
    input  wire  out_stall,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register is free or drains now
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lkv_datapath.sv
// Datapath: entry store, parallel key compare, recency ranks and result register.
`default_nettype none
module lkv_datapath
    import lkv_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire  [CAP_W-1:0] cfg_wdata,
    input  req_t             in_data,
    input  cmd_t             cmd,
    output rsp_t             out_data
);

    logic [CAP_W-1:0]      cap_reg;
    req_t                  req_reg;
    logic signed [31:0]    key_reg   [MAX_ENTRIES];
    logic signed [31:0]    value_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank_reg  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]      count_reg;
    rsp_t                  rsp_reg;

    // search results
    logic                  hit_reg, hit_next;
    logic                  full_reg, full_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]      victim_idx_reg, victim_idx_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;

    logic [CMP_W-1:0]      eff_cap;
    logic [IDX_W-1:0]      oldest_rank;
    logic [IDX_W-1:0]      target;
    logic [CNT_W-1:0]      threshold;
    logic                  do_update;
    logic                  do_insert;
    logic                  do_evict;

    assign out_data = rsp_reg;

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES))
            eff_cap = CMP_W'(MAX_ENTRIES);
        else
            eff_cap = CMP_W'(cap_reg);
    end

    // ranks of valid entries form 0..count-1, so the oldest has rank count-1
    assign oldest_rank = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        hit_next        = 1'b0;
        hit_idx_next    = '0;
        victim_idx_next = '0;
        free_idx_next   = '0;
        full_next       = (CMP_W'(count_reg) >= eff_cap);
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (valid_reg[i] && key_reg[i] == req_reg.key)
            begin
                hit_next     = 1'b1;
                hit_idx_next = hit_idx_next | IDX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == oldest_rank)
                victim_idx_next = victim_idx_next | IDX_W'(i);
        end
        // lowest free slot wins
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx_next = IDX_W'(i);
        end
    end

    always_comb
    begin
        do_update = hit_reg || (req_reg.op == OP_WRITE);
        do_evict  = !hit_reg && (req_reg.op == OP_WRITE) && full_reg;
        do_insert = !hit_reg && (req_reg.op == OP_WRITE) && !full_reg;
        priority if (hit_reg)
            target = hit_idx_reg;
        else if (full_reg)
            target = victim_idx_reg;
        else
            target = free_idx_reg;
        // an insert ages every valid entry, since all ranks sit below count
        if (do_insert)
            threshold = count_reg;
        else
            threshold = CNT_W'(rank_reg[target]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (cmd.commit && do_update)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (IDX_W'(i) == target)
                        rank_reg[i] <= '0;
                    else if (valid_reg[i] && CNT_W'(rank_reg[i]) < threshold)
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                end
            end
            if (cmd.commit && do_insert)
            begin
                valid_reg[target] <= 1'b1;
                count_reg         <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_data;
        if (cmd.search)
        begin
            hit_reg        <= hit_next;
            full_reg       <= full_next;
            hit_idx_reg    <= hit_idx_next;
            victim_idx_reg <= victim_idx_next;
            free_idx_reg   <= free_idx_next;
        end
        if (cmd.commit)
        begin
            if (req_reg.op == OP_WRITE)
                value_reg[target] <= req_reg.write_value;
            if (do_evict || do_insert)
                key_reg[target] <= req_reg.key;
            rsp_reg.hit         <= hit_reg;
            rsp_reg.evicted     <= do_evict;
            rsp_reg.evicted_key <= do_evict ? key_reg[target] : 32'sd0;
            if (req_reg.op == OP_WRITE)
                rsp_reg.read_value <= 32'sd0;
            else if (hit_reg)
                rsp_reg.read_value <= value_reg[target];
            else
                rsp_reg.read_value <= MISS_VALUE;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lru_key_value_cache_top.sv
// Top level: fully associative key-value cache with least-recently-used replacement.
// Sequence: a transaction accepted in idle is captured, then searched against every key in
//   parallel, then committed to the output register; commit waits while the output stalls.
// The controller takes one transaction at a time through capture, search and commit and
//   stalls its input meanwhile; the next request is taken while a result waits in the output.
// Reset (rst_n, async, active low): the store is empty, capacity reads 16, no result pending.
`default_nettype none
module lru_key_value_cache_top
    import lkv_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire  [CAP_W-1:0] cfg_wdata,
    input  wire              in_valid,
    output logic             in_stall,
    input  req_t             in_data,
    output logic             out_valid,
    input  wire              out_stall,
    output rsp_t             out_data
);

    cmd_t cmd;

    // Controller: one request in flight; hold commit while the output is stalled.
    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: compare all sixteen keys at once, pick hit, victim or free slot,
    // then update values and ranks and load the result register on commit.
    lkv_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/lkv_checker.sv
// Checker: port-level assertions for the cache top level, bound to it.
`default_nettype none
module lkv_checker
    import lkv_pkg::*;
(
    input wire             clk,
    input wire             rst_n,
    input wire             in_valid,
    input wire             in_stall,
    input wire             out_valid,
    input wire             out_stall,
    input rsp_t            out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one transaction in flight: stall right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

    // every accepted transaction shows a valid result once search and commit have followed the capture
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##3 out_valid)
        else $error("result missing after accept");

    // an eviction only comes from a write miss
    a_evict_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.evicted |-> !out_data.hit && out_data.read_value == 32'sd0)
        else $error("eviction on a hit or lookup");

    // no eviction reports a zero key
    a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.evicted |-> out_data.evicted_key == 32'sd0)
        else $error("evicted key set without eviction");

endmodule

bind lru_key_value_cache_top lkv_checker u_checker (.*);
`default_nettype wire

FILE: test/lru_key_value_cache_checker.sv
// Checker: predicts the LRU key-value cache and compares every response transaction.
module lru_key_value_cache_checker
    import lkv_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire  [CAP_W-1:0] cfg_wdata,
    input  wire              in_valid,
    input  wire              in_stall,
    input  req_t             in_data,
    input  wire              out_valid,
    input  wire              out_stall,
    input  rsp_t             out_data,
    output int               fail_count,
    output int               outstanding,
    output int               results_seen,
    output int               hits_seen,
    output int               evictions_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] slot_key   [MAX_ENTRIES];
    logic signed [31:0] slot_value [MAX_ENTRIES];
    logic               slot_used  [MAX_ENTRIES];
    logic [IDX_W-1:0]   slot_rank  [MAX_ENTRIES];
    logic [CNT_W-1:0]   used_count;
    logic [CAP_W-1:0]   capacity;

    rsp_t               expected_rsp_q [$];
    rsp_t               want;
    int                 mismatches;
    int                 n_results;
    int                 n_hits;
    int                 n_evictions;

    // Rank 0 is the most recent; entries that were more recent than s age by one.
    function automatic void make_most_recent(int s);
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_used[i] && i != s && slot_rank[i] < slot_rank[s])
                slot_rank[i] = slot_rank[i] + 1'b1;
        slot_rank[s] = '0;
    endfunction

    function automatic rsp_t cache_access(req_t r);
        rsp_t res;
        int   found;
        int   victim;
        int   free_slot;
        int   cap;
        res       = '0;
        found     = -1;
        victim    = -1;
        free_slot = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (found < 0 && slot_used[i] && slot_key[i] == r.key)
                found = i;
        // Zero acts as one, anything past the store size as the store size.
        if (capacity == 0)
            cap = 1;
        else if (capacity > MAX_ENTRIES)
            cap = MAX_ENTRIES;
        else
            cap = int'(capacity);

        if (r.op == OP_LOOKUP) begin
            if (found >= 0) begin
                res.hit        = 1'b1;
                res.read_value = slot_value[found];
                make_most_recent(found);
            end
            else
                res.read_value = MISS_VALUE;
        end
        else if (found >= 0) begin
            res.hit           = 1'b1;
            slot_value[found] = r.write_value;
            make_most_recent(found);
        end
        else if (int'(used_count) >= cap) begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                    victim = i;
            res.evicted        = 1'b1;
            res.evicted_key    = slot_key[victim];
            slot_key[victim]   = r.key;
            slot_value[victim] = r.write_value;
            make_most_recent(victim);
        end
        else begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot_used[i])
                    slot_rank[i] = slot_rank[i] + 1'b1;
            slot_used[free_slot]  = 1'b1;
            slot_key[free_slot]   = r.key;
            slot_value[free_slot] = r.write_value;
            slot_rank[free_slot]  = '0;
            used_count            = used_count + 1'b1;
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %h, actual %h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_rank[i] = '0;
            end
            used_count = '0;
            capacity   = CAP_RESET;
            expected_rsp_q.delete();
        end
        else begin
            // Retire the response first: it always belongs to an older request.
            if (out_valid && !out_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("response transaction with no request outstanding: %p", out_data);
                    mismatches++;
                end
                else begin
                    want = expected_rsp_q.pop_front();
                    check_field("hit", 32'(want.hit), 32'(out_data.hit));
                    check_field("read_value", want.read_value, out_data.read_value);
                    check_field("evicted", 32'(want.evicted), 32'(out_data.evicted));
                    check_field("evicted_key", want.evicted_key, out_data.evicted_key);
                    n_results++;
                    if (want.hit)
                        n_hits++;
                    if (want.evicted)
                        n_evictions++;
                end
            end
            if (cfg_we)
                capacity = cfg_wdata;
            if (in_valid && !in_stall)
                expected_rsp_q.push_back(cache_access(in_data));
        end
        fail_count     <= mismatches;
        outstanding    <= expected_rsp_q.size();
        results_seen   <= n_results;
        hits_seen      <= n_hits;
        evictions_seen <= n_evictions;
    end

endmodule

FILE: test/lru_key_value_cache_top_tb.sv
// Testbench top: drives requests, capacity writes and receiver stalls for the LRU cache.
module lru_key_value_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lkv_pkg::*;

    localparam int POOL_SIZE      = 24;
    localparam int PHASE_ITEMS    = 140;
    localparam int SQUEEZE_CYCLES = 60;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    req_t             in_data   = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    rsp_t             out_data;

    int fail_count;
    int outstanding;
    int results_seen;
    int hits_seen;
    int evictions_seen;

    // Stimulus bookkeeping.
    logic signed [31:0] key_pool [POOL_SIZE];
    int                 pool_span  = POOL_SIZE;
    bit                 burst_mode = 1'b0;
    int                 sent       = 0;
    int                 cfg_writes = 0;
    logic               squeeze    = 1'b0;

    // Receiver state.
    logic squeezed   = 1'b0;
    int   stall_left = 0;
    int   calm_left  = 0;
    int   rx_roll;

    lru_key_value_cache_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    lru_key_value_cache_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("lru_key_value_cache_top_tb failed");
        $finish;
    end

    // Receiver: mostly ready, short stalls, the odd long one, and calm stretches
    // with no stall at all. The one-shot squeeze holds the output off long enough
    // that the cache backs up and stalls its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            calm_left  <= 0;
            squeezed   <= 1'b0;
        end
        else if (squeeze && !squeezed)
        begin
            squeezed   <= 1'b1;
            stall_left <= SQUEEZE_CYCLES;
            out_stall  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (calm_left != 0)
        begin
            calm_left <= calm_left - 1;
            out_stall <= 1'b0;
        end
        else
        begin
            rx_roll = $urandom_range(0, 199);
            if (rx_roll < 130)
                out_stall <= 1'b0;
            else if (rx_roll < 185)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
            else if (rx_roll < 192)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
            else
            begin
                out_stall <= 1'b0;
                calm_left <= $urandom_range(30, 120);
            end
        end
    end

    function automatic req_t make_req(logic op, logic signed [31:0] k, logic signed [31:0] v);
        req_t r;
        r.op          = op;
        r.key         = k;
        r.write_value = v;
        return r;
    endfunction

    // Draw most keys from a pool a little larger than the capacity in use, so
    // lookups hit, rewrites update and new keys evict; the rest are fresh keys
    // that almost always miss. Churn the pool now and then.
    function automatic req_t random_request();
        req_t r;
        int   roll;
        roll          = $urandom_range(0, 99);
        r.op          = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_LOOKUP;
        r.write_value = $urandom;
        if (roll < 75)
            r.key = key_pool[$urandom_range(0, pool_span - 1)];
        else
            r.key = $urandom;
        if (roll >= 97)
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one transaction and hold it until taken; keep valid high when the
    // next one follows back to back, otherwise drop it and scramble the idle bus.
    task automatic send_request(req_t r, int gap);
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= {1'($urandom), 32'($urandom), 32'($urandom)};
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every predicted response to come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Write the capacity only with the cache idle.
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        logic [CAP_W-1:0] cap_plan [12];
        int               eff;
        cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd12, 5'd8, 5'd3,
                     5'd16, 5'd24};
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: a lookup misses and leaves the state alone.
        send_request(make_req(OP_LOOKUP, 32'sd0, 32'sd0), pick_gap());
        // Insert the extreme keys and values.
        send_request(make_req(OP_WRITE, 32'sh8000_0000, 32'sh7FFF_FFFF), pick_gap());
        send_request(make_req(OP_WRITE, 32'sh7FFF_FFFF, 32'sh8000_0000), pick_gap());
        send_request(make_req(OP_WRITE, -32'sd1, 32'sd0), pick_gap());
        send_request(make_req(OP_WRITE, 32'sd0, -32'sd1), pick_gap());
        // Hit each one and miss on key 1; a stored all-ones value must not read as a miss.
        send_request(make_req(OP_LOOKUP, 32'sh8000_0000, 32'sd0), pick_gap());
        send_request(make_req(OP_LOOKUP, 32'sh7FFF_FFFF, -32'sd1), pick_gap());
        send_request(make_req(OP_LOOKUP, -32'sd1, 32'sd7), pick_gap());
        send_request(make_req(OP_LOOKUP, 32'sd0, 32'sd0), pick_gap());
        send_request(make_req(OP_LOOKUP, 32'sd1, 32'sd0), pick_gap());
        // Rewrite a present key, then read it back.
        send_request(make_req(OP_WRITE, -32'sd1, 32'sh1357_9BDF), pick_gap());
        send_request(make_req(OP_LOOKUP, -32'sd1, 32'sd0), pick_gap());

        // Capacity dropped below the count: each new key evicts exactly one.
        set_capacity(5'd2);
        send_request(make_req(OP_WRITE, 32'sh100, 32'sd1), pick_gap());
        send_request(make_req(OP_WRITE, 32'sh200, 32'sd2), pick_gap());
        send_request(make_req(OP_LOOKUP, 32'sh8000_0000, 32'sd0), pick_gap());

        // Zero capacity behaves as one entry.
        set_capacity(5'd0);
        send_request(make_req(OP_WRITE, 32'sh300, 32'sd3), pick_gap());
        send_request(make_req(OP_WRITE, 32'sh300, 32'sd4), pick_gap());
        send_request(make_req(OP_LOOKUP, 32'sh300, 32'sd0), pick_gap());

        // Oversized capacity clamps to the store size; new keys take free slots.
        set_capacity(5'd31);
        send_request(make_req(OP_WRITE, 32'sh400, 32'sd5), pick_gap());
        send_request(make_req(OP_WRITE, 32'sh500, 32'sd6), pick_gap());
        send_request(make_req(OP_LOOKUP, 32'sh100, 32'sd0), pick_gap());

        // Random phases, one capacity each. Every fourth phase from the second runs back to back;
        // so does the third, which also squeezes the receiver.
        foreach (cap_plan[p])
        begin
            set_capacity(cap_plan[p]);
            if (cap_plan[p] == 0)
                eff = 1;
            else if (cap_plan[p] > MAX_ENTRIES)
                eff = MAX_ENTRIES;
            else
                eff = int'(cap_plan[p]);
            pool_span  = (eff + 3 > POOL_SIZE) ? POOL_SIZE : eff + 3;
            burst_mode = (p % 4 == 1) || (p == 2);
            if (p == 2)
                squeeze <= 1'b1;
            repeat (PHASE_ITEMS) send_request(random_request(), pick_gap());
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Sent %0d requests over %0d capacity writes, including 0, 1, 16, 17 and 31.",
                 sent, cfg_writes);
        $display("Checked %0d responses: %0d hits, %0d evictions.",
                 results_seen, hits_seen, evictions_seen);
        if (fail_count == 0)
            $display("lru_key_value_cache_top_tb passed");
        else
            $display("lru_key_value_cache_top_tb failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/lkv_pkg.sv
rtl/lkv_ctrl.sv
rtl/lkv_datapath.sv
rtl/lru_key_value_cache_top.sv
rtl/lkv_checker.sv
test/lru_key_value_cache_checker.sv
test/lru_key_value_cache_top_tb.sv
